// ===== hdl/fld_pkg.sv =====
// Shared constants and types for the four-level soft demapper.
`default_nettype none
package fld_pkg;
	localparam int NUM_LEVELS = 4;
	localparam int LUMA_W = 16;
	localparam int VAR_W = 22;
	localparam int MAP_W = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DIST_W = 32;
	localparam int METRIC_W = 16;
	localparam int MARGIN_W = 16;

	// Quotient bits per divider; all three dividers share the same latency.
	localparam int DIV_QW = 17;
	localparam int METRIC_NW = 49;
	localparam int MARGIN_NW = 50;
	localparam int METRIC_TAG_W = 18;
	localparam int MARGIN_TAG_W = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTROID0 = 3'd0,
		REG_CENTROID1 = 3'd1,
		REG_CENTROID2 = 3'd2,
		REG_CENTROID3 = 3'd3,
		REG_GAP       = 3'd4,
		REG_MAP       = 3'd5
	} reg_idx_t;

	localparam logic [LUMA_W-1:0] CENTROID0_RST = 16'd0;
	localparam logic [LUMA_W-1:0] CENTROID1_RST = 16'd21760;
	localparam logic [LUMA_W-1:0] CENTROID2_RST = 16'd43520;
	localparam logic [LUMA_W-1:0] CENTROID3_RST = 16'd65280;
	localparam logic [LUMA_W-1:0] GAP_RST = 16'd21760;
	localparam logic [MAP_W-1:0] MAP_RST = 8'd228;

	localparam logic [METRIC_W-1:0] METRIC_POS_SAT = 16'h7FFF;
	localparam logic [METRIC_W-1:0] METRIC_NEG_SAT = 16'h8000;

	// Sideband that rides along with a metric division.
	typedef struct packed {
		logic use_fixed;
		logic [METRIC_W-1:0] fixed_val;
		logic neg;
	} metric_tag_t;

	typedef struct packed {
		logic [1:0] label;
		logic unreliable;
		logic sum_zero;
	} margin_tag_t;
endpackage
`default_nettype wire

// ===== hdl/fld_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module fld_div_pipe #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int QW = 17,
	parameter int TW = 4
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	input  wire logic [TW-1:0] tag,
	output logic      [QW-1:0] quo,
	output logic      [TW-1:0] tag_out
);
	logic [NW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic [TW-1:0] tag_s [QW];

	for (genvar i = 0; i < QW; i++) begin : g_stage
		localparam int K = QW - 1 - i;
		logic [NW-1:0] rp;
		logic [DW-1:0] dp;
		logic [QW-1:0] qp;
		logic [TW-1:0] tp;
		logic [NW-1:0] trial;
		logic ge;

		if (i == 0) begin : g_first
			assign rp = num;
			assign dp = den;
			assign qp = '0;
			assign tp = tag;
		end else begin : g_next
			assign rp = rem_s[i-1];
			assign dp = den_s[i-1];
			assign qp = quo_s[i-1];
			assign tp = tag_s[i-1];
		end

		assign trial = NW'(dp) << K;
		assign ge = rp >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? rp - trial : rp;
				den_s[i] <= dp;
				quo_s[i] <= qp | (QW'(ge) << K);
				tag_s[i] <= tp;
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign tag_out = tag_s[QW-1];
endmodule
`default_nettype wire

// ===== hdl/four_level_soft_demapper_core.sv =====
// Top level of the four-level max-log soft demapper pipeline.
// One tile enters per clock cycle while the pipeline is not held. Registered
// stages compute distances, group minima and division operands, then the
// one-bit-per-stage dividers produce the soft metrics and margin, and a final
// register stage forms the saturated outputs. The whole pipeline advances
// together and holds when the output register is full and not taken.
`default_nettype none
module four_level_soft_demapper_core (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [fld_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [fld_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [fld_pkg::LUMA_W-1:0]    tile_mean,
	input  wire logic [fld_pkg::VAR_W-1:0]     tile_variance,
	input  wire logic                          tile_clipped,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [1:0]                         hard_label,
	output logic signed [fld_pkg::METRIC_W-1:0] soft_metric_bit0,
	output logic signed [fld_pkg::METRIC_W-1:0] soft_metric_bit1,
	output logic [fld_pkg::MARGIN_W-1:0]       decision_margin,
	output logic                               unreliable_flag
);
	import fld_pkg::*;

	localparam int QW = DIV_QW;

	logic [LUMA_W-1:0] centroid_q [NUM_LEVELS];
	logic [LUMA_W-1:0] gap_q;
	logic [MAP_W-1:0] map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centroid_q[0] <= CENTROID0_RST;
			centroid_q[1] <= CENTROID1_RST;
			centroid_q[2] <= CENTROID2_RST;
			centroid_q[3] <= CENTROID3_RST;
			gap_q <= GAP_RST;
			map_q <= MAP_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTROID0: centroid_q[0] <= cfg_wdata;
				REG_CENTROID1: centroid_q[1] <= cfg_wdata;
				REG_CENTROID2: centroid_q[2] <= cfg_wdata;
				REG_CENTROID3: centroid_q[3] <= cfg_wdata;
				REG_GAP: gap_q <= cfg_wdata;
				REG_MAP: map_q <= cfg_wdata[MAP_W-1:0];
				default: ;
			endcase
		end
	end

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [QW-1:0] vdiv_q;

	assign en = !out_valid || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			vdiv_q <= '0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			vdiv_q <= {vdiv_q[QW-2:0], v_s5};
			out_valid <= vdiv_q[QW-1];
		end
	end

	// Stage 1: absolute differences to each centroid.
	logic [LUMA_W-1:0] dabs_s1 [NUM_LEVELS];
	logic [VAR_W-1:0] var_s1;
	logic clip_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				dabs_s1[l] <= (tile_mean >= centroid_q[l]) ? tile_mean - centroid_q[l]
					: centroid_q[l] - tile_mean;
			end
			var_s1 <= tile_variance;
			clip_s1 <= tile_clipped;
		end
	end

	// Stage 2: squared distances and gap squared.
	logic [DIST_W-1:0] dist_s2 [NUM_LEVELS];
	logic [DIST_W-1:0] gsq_s2;
	logic [VAR_W-1:0] var_s2;
	logic clip_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < NUM_LEVELS; l++) begin
				dist_s2[l] <= DIST_W'(dabs_s1[l]) * DIST_W'(dabs_s1[l]);
			end
			gsq_s2 <= DIST_W'(gap_q) * DIST_W'(gap_q);
			var_s2 <= var_s1;
			clip_s2 <= clip_s1;
		end
	end

	// Stage 3: group minima per label bit, two smallest distances, reliability.
	logic [DIST_W-1:0] one_d_c [2];
	logic [DIST_W-1:0] zero_d_c [2];
	logic [1:0] one_seen_c, zero_seen_c, label_c;
	logic [DIST_W-1:0] first_c, second_c;
	logic unrel_c;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			one_d_c[b] = '0;
			zero_d_c[b] = '0;
			one_seen_c[b] = 1'b0;
			zero_seen_c[b] = 1'b0;
			for (int l = 0; l < NUM_LEVELS; l++) begin
				if (map_q[2*l+b]) begin
					if (!one_seen_c[b] || dist_s2[l] < one_d_c[b]) begin
						one_d_c[b] = dist_s2[l];
					end
					one_seen_c[b] = 1'b1;
				end else begin
					if (!zero_seen_c[b] || dist_s2[l] < zero_d_c[b]) begin
						zero_d_c[b] = dist_s2[l];
					end
					zero_seen_c[b] = 1'b1;
				end
			end
			label_c[b] = one_seen_c[b] && (!zero_seen_c[b] || one_d_c[b] < zero_d_c[b]);
		end
		first_c = dist_s2[0];
		second_c = '1;
		for (int l = 1; l < NUM_LEVELS; l++) begin
			if (dist_s2[l] < first_c) begin
				second_c = first_c;
				first_c = dist_s2[l];
			end else if (dist_s2[l] < second_c) begin
				second_c = dist_s2[l];
			end
		end
		unrel_c = clip_s2 || ({var_s2, 12'b0} > {2'b0, gsq_s2});
	end

	logic [DIST_W-1:0] one_d_s3 [2];
	logic [DIST_W-1:0] zero_d_s3 [2];
	logic [1:0] one_seen_s3, zero_seen_s3, label_s3;
	logic [DIST_W-1:0] first_s3, second_s3, gsq_s3;
	logic unrel_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			one_d_s3 <= one_d_c;
			zero_d_s3 <= zero_d_c;
			one_seen_s3 <= one_seen_c;
			zero_seen_s3 <= zero_seen_c;
			label_s3 <= label_c;
			first_s3 <= first_c;
			second_s3 <= second_c;
			gsq_s3 <= gsq_s2;
			unrel_s3 <= unrel_c;
		end
	end

	// Stage 4: distance differences, special cases, margin operands.
	logic [DIST_W-1:0] mag_s4 [2];
	metric_tag_t mtag_s4 [2];
	logic [DIST_W:0] msum_s4;
	logic [DIST_W-1:0] mdiff_s4, gsq_s4;
	logic [1:0] label_s4;
	logic unrel_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				metric_tag_t mt;
				mt.neg = one_d_s3[b] < zero_d_s3[b];
				mt.use_fixed = 1'b1;
				if (unrel_s3) begin
					mt.fixed_val = '0;
				end else if (!one_seen_s3[b]) begin
					mt.fixed_val = METRIC_POS_SAT;
				end else if (!zero_seen_s3[b]) begin
					mt.fixed_val = METRIC_NEG_SAT;
				end else if (one_d_s3[b] == zero_d_s3[b]) begin
					mt.fixed_val = '0;
				end else if (gsq_s3 == '0) begin
					mt.fixed_val = mt.neg ? METRIC_NEG_SAT : METRIC_POS_SAT;
				end else begin
					mt.use_fixed = 1'b0;
					mt.fixed_val = '0;
				end
				mtag_s4[b] <= mt;
				mag_s4[b] <= (one_d_s3[b] < zero_d_s3[b]) ? zero_d_s3[b] - one_d_s3[b]
					: one_d_s3[b] - zero_d_s3[b];
			end
			msum_s4 <= {1'b0, first_s3} + {1'b0, second_s3};
			mdiff_s4 <= second_s3 - first_s3;
			gsq_s4 <= gsq_s3;
			label_s4 <= label_s3;
			unrel_s4 <= unrel_s3;
		end
	end

	// Stage 5: rounded numerators and quotient range check.
	logic [METRIC_NW-1:0] mnum_s5 [2];
	metric_tag_t mtag_s5 [2];
	logic [DIST_W-1:0] gsq_s5;
	logic [MARGIN_NW-1:0] gnum_s5;
	logic [DIST_W:0] msum_s5;
	margin_tag_t gtag_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int b = 0; b < 2; b++) begin
				logic [METRIC_NW-1:0] num;
				logic ovf;
				metric_tag_t mt;
				num = METRIC_NW'({mag_s4[b], 8'b0}) + METRIC_NW'(gsq_s4 >> 1);
				// A quotient that would not fit in the divider saturates anyway.
				ovf = num >= METRIC_NW'({gsq_s4, QW'(0)});
				mt = mtag_s4[b];
				if (!mt.use_fixed && ovf) begin
					mt.use_fixed = 1'b1;
					mt.fixed_val = mt.neg ? METRIC_NEG_SAT : METRIC_POS_SAT;
				end
				mtag_s5[b] <= mt;
				mnum_s5[b] <= mt.use_fixed ? '0 : num;
			end
			gsq_s5 <= gsq_s4;
			gnum_s5 <= MARGIN_NW'({mdiff_s4, 16'b0}) + MARGIN_NW'(msum_s4 >> 1);
			msum_s5 <= msum_s4;
			gtag_s5.label <= label_s4;
			gtag_s5.unreliable <= unrel_s4;
			gtag_s5.sum_zero <= msum_s4 == '0;
		end
	end

	logic [QW-1:0] mq [2];
	metric_tag_t mtag_d [2];
	logic [QW-1:0] gq;
	margin_tag_t gtag_d;

	for (genvar b = 0; b < 2; b++) begin : g_metric_div
		fld_div_pipe #(
			.NW(METRIC_NW),
			.DW(DIST_W),
			.QW(QW),
			.TW(METRIC_TAG_W)
		) u_div (
			.clk(clk),
			.en(en),
			.num(mnum_s5[b]),
			.den(gsq_s5),
			.tag(mtag_s5[b]),
			.quo(mq[b]),
			.tag_out(mtag_d[b])
		);
	end

	fld_div_pipe #(
		.NW(MARGIN_NW),
		.DW(DIST_W + 1),
		.QW(QW),
		.TW(MARGIN_TAG_W)
	) u_margin_div (
		.clk(clk),
		.en(en),
		.num(gnum_s5),
		.den(msum_s5),
		.tag(gtag_s5),
		.quo(gq),
		.tag_out(gtag_d)
	);

	// Output stage: sign, saturation and special values.
	logic [METRIC_W-1:0] metric_c [2];
	logic [MARGIN_W-1:0] margin_c;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			if (mtag_d[b].use_fixed) begin
				metric_c[b] = mtag_d[b].fixed_val;
			end else if (mtag_d[b].neg) begin
				metric_c[b] = (mq[b] > QW'(32768)) ? METRIC_NEG_SAT
					: METRIC_W'(QW'(0) - mq[b]);
			end else begin
				metric_c[b] = (mq[b] > QW'(32767)) ? METRIC_POS_SAT : METRIC_W'(mq[b]);
			end
		end
		if (gtag_d.sum_zero) begin
			margin_c = '0;
		end else if (gq > QW'(65535)) begin
			margin_c = '1;
		end else begin
			margin_c = MARGIN_W'(gq);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hard_label <= gtag_d.label;
			soft_metric_bit0 <= metric_c[0];
			soft_metric_bit1 <= metric_c[1];
			decision_margin <= margin_c;
			unreliable_flag <= gtag_d.unreliable;
		end
	end
endmodule
`default_nettype wire
